@@ rtl/tsc_pkg.sv @@
// tsc_pkg: constants, types and the reciprocal table for the Taylor sine/cosine pipeline.
// No dependencies; used by every other file in rtl/.
package tsc_pkg;

  localparam int MAX_TERMS = 16;
  localparam int FRAC_BITS = 28;
  localparam int ANG_W     = 31;
  localparam int VAL_W     = 30;
  localparam int CNT_W     = 5;
  localparam int EPS_W     = 10;
  localparam logic [EPS_W-1:0] EPS_RESET = 10'd27;

  localparam int N_W    = $clog2(MAX_TERMS + 1);
  localparam int M_W    = N_W + 1;
  localparam int X2_W   = 33;
  localparam int TMAG_W = 34;
  localparam int P1_W   = 39;
  localparam int SUM_W  = 40;
  localparam int RCP_W  = 28;

  // Item as it travels between term stages; term kept as sign and magnitude.
  typedef struct packed {
    logic                    valid;
    logic                    s;
    logic [X2_W-1:0]         x2;
    logic                    tneg;
    logic [TMAG_W-1:0]       tmag;
    logic signed [SUM_W-1:0] sum;
    logic [N_W-1:0]          n;
    logic                    done;
  } tsc_item_t;

  // Item halfway through a term stage, after the first product.
  typedef struct packed {
    logic                    valid;
    logic                    s;
    logic [X2_W-1:0]         x2;
    logic                    tneg;
    logic [P1_W-1:0]         p1;
    logic [M_W-1:0]          m;
    logic signed [SUM_W-1:0] sum;
    logic [N_W-1:0]          n;
    logic                    done;
  } tsc_mid_t;

  // 1/(m*(m-1)) in Q.28, rounded to nearest.
  function automatic logic [RCP_W-1:0] recip(input logic [M_W-1:0] m);
    logic [RCP_W-1:0] r;
    case (m)
      6'd2:    r = 28'd134217728;
      6'd3:    r = 28'd44739243;
      6'd4:    r = 28'd22369621;
      6'd5:    r = 28'd13421773;
      6'd6:    r = 28'd8947849;
      6'd7:    r = 28'd6391320;
      6'd8:    r = 28'd4793490;
      6'd9:    r = 28'd3728270;
      6'd10:   r = 28'd2982616;
      6'd11:   r = 28'd2440322;
      6'd12:   r = 28'd2033602;
      6'd13:   r = 28'd1720740;
      6'd14:   r = 28'd1474920;
      6'd15:   r = 28'd1278264;
      6'd16:   r = 28'd1118481;
      6'd17:   r = 28'd986895;
      6'd18:   r = 28'd877240;
      6'd19:   r = 28'd784899;
      6'd20:   r = 28'd706409;
      6'd21:   r = 28'd639132;
      6'd22:   r = 28'd581029;
      6'd23:   r = 28'd530505;
      6'd24:   r = 28'd486296;
      6'd25:   r = 28'd447392;
      6'd26:   r = 28'd412978;
      6'd27:   r = 28'd382387;
      6'd28:   r = 28'd355073;
      6'd29:   r = 28'd330586;
      6'd30:   r = 28'd308547;
      6'd31:   r = 28'd288640;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/tsc_in_if.sv @@
// tsc_in_if: input channel (cmd, angle) with valid/ready.
// Depends on tsc_pkg.
interface tsc_in_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic signed [tsc_pkg::ANG_W-1:0]   angle;
  modport source (output valid, cmd, angle, input ready);
  modport sink (input valid, cmd, angle, output ready);
endinterface

@@ rtl/tsc_out_if.sv @@
// tsc_out_if: result channel (value, terms_used) with valid/ready.
// Depends on tsc_pkg.
interface tsc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [tsc_pkg::VAL_W-1:0]   value;
  logic [tsc_pkg::CNT_W-1:0]          terms_used;
  modport source (output valid, value, terms_used, input ready);
  modport sink (input valid, value, terms_used, output ready);
endinterface

@@ rtl/tsc_prep.sv @@
// tsc_prep: angle to magnitude, x squared, first term; one register stage.
// Depends on tsc_pkg.
module tsc_prep (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic                             in_cmd,
  input  logic signed [tsc_pkg::ANG_W-1:0] in_angle,
  output tsc_pkg::tsc_item_t               item_r
);
  import tsc_pkg::*;

  logic                      aneg;
  logic [ANG_W-1:0]          amag;
  logic [2*ANG_W-1:0]        sq;
  tsc_item_t                 item_nxt;

  always_comb begin
    aneg = in_angle[ANG_W-1];
    amag = aneg ? ANG_W'(-in_angle) : ANG_W'(in_angle);
    sq   = amag * amag + (2*ANG_W)'(64'd1 << (FRAC_BITS - 1));
    item_nxt       = '0;
    item_nxt.valid = in_valid;
    item_nxt.s     = in_cmd;
    item_nxt.x2    = sq[FRAC_BITS +: X2_W];
    item_nxt.tneg  = in_cmd ? aneg : 1'b0;
    item_nxt.tmag  = in_cmd ? TMAG_W'(amag) : TMAG_W'(64'd1 << FRAC_BITS);
    item_nxt.sum   = '0;
    item_nxt.n     = '0;
    item_nxt.done  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else if (en) begin
      item_r.valid <= item_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r.s    <= item_nxt.s;
      item_r.x2   <= item_nxt.x2;
      item_r.tneg <= item_nxt.tneg;
      item_r.tmag <= item_nxt.tmag;
      item_r.sum  <= item_nxt.sum;
      item_r.n    <= item_nxt.n;
      item_r.done <= item_nxt.done;
    end
  end

endmodule

@@ rtl/tsc_term.sv @@
// tsc_term: one series term in two register stages: add and term*x2, then *recip.
// Depends on tsc_pkg.
module tsc_term (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [tsc_pkg::EPS_W-1:0] eps,
  input  tsc_pkg::tsc_item_t        item_i,
  output tsc_pkg::tsc_item_t        item_r
);
  import tsc_pkg::*;

  tsc_mid_t                      mid_r;
  tsc_mid_t                      mid_nxt;
  tsc_item_t                     item_nxt;
  logic                          live;
  logic [N_W-1:0]                n_inc;
  logic [TMAG_W+X2_W-1:0]        prod1;
  logic [P1_W+RCP_W-1:0]         prod2;
  logic signed [SUM_W-1:0]       tval;

  always_comb begin
    live  = !item_i.done && (item_i.tmag > TMAG_W'(eps));
    n_inc = item_i.n + N_W'(1);
    tval  = item_i.tneg ? -SUM_W'(item_i.tmag) : SUM_W'(item_i.tmag);
    prod1 = item_i.tmag * item_i.x2
          + (TMAG_W+X2_W)'(64'd1 << (FRAC_BITS - 1));
    mid_nxt.valid = item_i.valid;
    mid_nxt.s     = item_i.s;
    mid_nxt.x2    = item_i.x2;
    mid_nxt.tneg  = ~item_i.tneg;
    mid_nxt.p1    = prod1[FRAC_BITS +: P1_W];
    mid_nxt.m     = {n_inc, item_i.s};
    mid_nxt.sum   = live ? item_i.sum + tval : item_i.sum;
    mid_nxt.n     = live ? n_inc : item_i.n;
    mid_nxt.done  = !live;
  end

  always_comb begin
    prod2 = mid_r.p1 * recip(mid_r.m)
          + (P1_W+RCP_W)'(64'd1 << (FRAC_BITS - 1));
    item_nxt.valid = mid_r.valid;
    item_nxt.s     = mid_r.s;
    item_nxt.x2    = mid_r.x2;
    item_nxt.tneg  = mid_r.tneg;
    item_nxt.tmag  = prod2[FRAC_BITS +: TMAG_W];
    item_nxt.sum   = mid_r.sum;
    item_nxt.n     = mid_r.n;
    item_nxt.done  = mid_r.done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r.valid  <= 1'b0;
      item_r.valid <= 1'b0;
    end else if (en) begin
      mid_r.valid  <= mid_nxt.valid;
      item_r.valid <= item_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid_r.s     <= mid_nxt.s;
      mid_r.x2    <= mid_nxt.x2;
      mid_r.tneg  <= mid_nxt.tneg;
      mid_r.p1    <= mid_nxt.p1;
      mid_r.m     <= mid_nxt.m;
      mid_r.sum   <= mid_nxt.sum;
      mid_r.n     <= mid_nxt.n;
      mid_r.done  <= mid_nxt.done;
      item_r.s    <= item_nxt.s;
      item_r.x2   <= item_nxt.x2;
      item_r.tneg <= item_nxt.tneg;
      item_r.tmag <= item_nxt.tmag;
      item_r.sum  <= item_nxt.sum;
      item_r.n    <= item_nxt.n;
      item_r.done <= item_nxt.done;
    end
  end

endmodule

@@ rtl/tsc_out.sv @@
// tsc_out: saturates the sum to [-1,1] and holds the result register.
// Depends on tsc_pkg and tsc_out_if.
module tsc_out (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  tsc_pkg::tsc_item_t item_i,
  tsc_out_if.source          out_ch
);
  import tsc_pkg::*;

  logic                      valid_r;
  logic signed [VAL_W-1:0]   value_r;
  logic [CNT_W-1:0]          terms_r;
  logic signed [VAL_W-1:0]   value_nxt;
  logic [CNT_W-1:0]          terms_nxt;
  logic                      sneg;
  logic [SUM_W-1:0]          smag;
  logic [VAL_W-1:0]          clip;

  always_comb begin
    sneg = item_i.sum[SUM_W-1];
    smag = sneg ? SUM_W'(-item_i.sum) : SUM_W'(item_i.sum);
    clip = (smag > SUM_W'(64'd1 << FRAC_BITS)) ? VAL_W'(64'd1 << FRAC_BITS)
                                               : smag[VAL_W-1:0];
    value_nxt = sneg ? -VAL_W'(clip) : VAL_W'(clip);
    terms_nxt = (item_i.n > N_W'(31)) ? CNT_W'(31) : CNT_W'(item_i.n);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= item_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value_r <= value_nxt;
      terms_r <= terms_nxt;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.value      = value_r;
  assign out_ch.terms_used = terms_r;

endmodule

@@ rtl/taylor_sine_cosine.sv @@
// taylor_sine_cosine: top level, cosine/sine of a Q3.28 angle by Maclaurin series.
// Depends on tsc_pkg, tsc_in_if, tsc_out_if, tsc_prep, tsc_term, tsc_out.
//
//   channel  dir  transaction             fields
//   in_ch    in   valid & ready           cmd (0 cos, 1 sin), angle Q3.28
//   out_ch   out  valid & ready           value Q2.28, terms_used
//   cfg_*    in   cfg_we                  cfg_wdata = epsilon_lsb (2^-28 units)
//
// The pipeline has one prep stage, two stages per term
// (add plus term*x2, then times the reciprocal), and one output stage.
// One transaction enters per cycle while out_ch is not stalled; the whole pipeline advances together.
// A stall on out_ch freezes every stage; nothing is dropped or repeated.
// Reset clears the valid bits and loads epsilon with its default of 27.
module taylor_sine_cosine (
  input  logic                      clk,
  input  logic                      rst_n,
  tsc_in_if.sink                    in_ch,
  tsc_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [tsc_pkg::EPS_W-1:0] cfg_wdata
);
  import tsc_pkg::*;

  logic [EPS_W-1:0] eps_r;
  logic             en;
  tsc_item_t        chain [MAX_TERMS+1];

  // whole pipe moves when the result register is free or being taken
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_we) begin
      eps_r <= cfg_wdata;
    end
  end

  tsc_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_angle (in_ch.angle),
    .item_r   (chain[0])
  );

  // one stage per series term; a stage only adds while its item is still live
  for (genvar k = 0; k < MAX_TERMS; k++) begin : g_term
    tsc_term u_term (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .eps    (eps_r),
      .item_i (chain[k]),
      .item_r (chain[k+1])
    );
  end

  tsc_out u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .item_i (chain[MAX_TERMS]),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  a_terms_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.terms_used <= CNT_W'(MAX_TERMS))
    else $error("terms_used above MAX_TERMS");

  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.value <= $signed(VAL_W'(64'd1 << FRAC_BITS))) &&
                     (out_ch.value >= -$signed(VAL_W'(64'd1 << FRAC_BITS))))
    else $error("value outside [-1,1]");

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.terms_used == '0) |-> out_ch.value == '0)
    else $error("nonzero value with no terms summed");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(chain[MAX_TERMS].valid))
    else $error("pipeline moved during a stall");
`endif

endmodule
